### design/cau_pkg.sv
package cau_pkg;

  localparam int DW  = 16;
  localparam int FW  = 8;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int RW  = 3 * DW + FW;

  localparam int CAU_LATENCY = DW + 5;

  localparam logic [SW-1:0] MAG_POS = SW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [SW-1:0] MAG_NEG = SW'(64'd1 << (DW - 1));

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_EQ  = 4'd4,
    CMD_NE  = 4'd5,
    CMD_LT  = 4'd6,
    CMD_GT  = 4'd7,
    CMD_LE  = 4'd8,
    CMD_GE  = 4'd9
  } cau_cmd_t;

  typedef struct packed {
    logic [3:0]           command;
    logic signed [DW-1:0] a_real;
    logic signed [DW-1:0] a_imag;
    logic signed [DW-1:0] b_real;
    logic signed [DW-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] result_real;
    logic signed [DW-1:0] result_imag;
    logic                 compare_true;
    logic [1:0]           status;
  } cau_out_t;

  // magnitude and sign to saturated value; returns {clamped, value}
  function automatic logic [DW:0] sat_mag(input logic [SW-1:0] m, input logic neg);
    logic [DW:0] r;
    if (neg) begin
      if (m > MAG_NEG) r = {1'b1, MAG_NEG[DW-1:0]};
      else             r = {1'b0, DW'(~m + 1'b1)};
    end else begin
      if (m > MAG_POS) r = {1'b1, MAG_POS[DW-1:0]};
      else             r = {1'b0, m[DW-1:0]};
    end
    return r;
  endfunction

endpackage

### design/cau_div.sv
module cau_div (
  input  logic                  clk,
  input  logic [cau_pkg::RW-1:0] num_i,
  input  logic [cau_pkg::PW-1:0] den_i,
  output logic [cau_pkg::DW-1:0] quo_o
);
  import cau_pkg::*;

  logic [RW-1:0] rem_r [DW];
  logic [PW-1:0] den_r [DW];
  logic [DW-1:0] quo_r [DW];

  logic [RW-1:0] rem_in  [DW];
  logic [PW-1:0] den_in  [DW];
  logic [DW-1:0] quo_in  [DW];
  logic [RW-1:0] sh      [DW];
  logic          take    [DW];
  logic [RW-1:0] rem_nxt [DW];
  logic [DW-1:0] quo_nxt [DW];

  always_comb begin
    for (int k = 0; k < DW; k++) begin
      if (k == 0) begin
        rem_in[k] = num_i;
        den_in[k] = den_i;
        quo_in[k] = '0;
      end else begin
        rem_in[k] = rem_r[k-1];
        den_in[k] = den_r[k-1];
        quo_in[k] = quo_r[k-1];
      end
      sh[k]      = RW'(den_in[k]) << (DW - 1 - k);
      take[k]    = (rem_in[k] >= sh[k]);
      rem_nxt[k] = take[k] ? (rem_in[k] - sh[k]) : rem_in[k];
      quo_nxt[k] = {quo_in[k][DW-2:0], take[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DW; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_in[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign quo_o = quo_r[DW-1];

endmodule

### design/complex_arithmetic_unit_core.sv
// channel  | ports                      | handshake
// input    | start, busy, in_data       | transaction taken when start && !busy
// result   | out_valid, out_data        | one-cycle strobe, no back-pressure
//
// One transaction per cycle; busy stays low. After acceptance a result passes
// four front stages (input register, products, sums, saturate/compare),
// one restoring-divider stage per quotient bit and one output register.
// Synchronous active-low reset clears the valid line; items in flight drop.
module complex_arithmetic_unit_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cau_pkg::cau_in_t in_data,
  output logic             out_valid,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  typedef struct packed {
    logic [3:0]    cmd;
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          sat;
    logic          cmp;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
  } ctl_t;

  assign busy = 1'b0;

  // stage 0: input register
  logic    v0_r;
  cau_in_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) s0_r <= in_data;
  end

  // stage 1: products, add/sub and equality
  logic                 v1_r;
  logic [3:0]           cmd1_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_aa_r, p_ab_r, p_ba_r, p_bb_r;
  logic signed [DW:0]   as1_r;
  logic                 eq1_r;
  logic signed [DW:0]   as_nxt;
  logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;

  assign ar_x = {s0_r.a_real[DW-1], s0_r.a_real};
  assign br_x = {s0_r.b_real[DW-1], s0_r.b_real};
  assign ai_x = {s0_r.a_imag[DW-1], s0_r.a_imag};
  assign bi_x = {s0_r.b_imag[DW-1], s0_r.b_imag};

  always_comb begin
    if (cau_cmd_t'(s0_r.command) == CMD_SUB) as_nxt = ar_x - br_x;
    else                                     as_nxt = ar_x + br_x;
  end

  logic signed [DW:0] asi_nxt;
  logic signed [DW:0] asi1_r;
  always_comb begin
    if (cau_cmd_t'(s0_r.command) == CMD_SUB) asi_nxt = ai_x - bi_x;
    else                                     asi_nxt = ai_x + bi_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    cmd1_r <= s0_r.command;
    p_rr_r <= s0_r.a_real * s0_r.b_real;
    p_ii_r <= s0_r.a_imag * s0_r.b_imag;
    p_ri_r <= s0_r.a_real * s0_r.b_imag;
    p_ir_r <= s0_r.a_imag * s0_r.b_real;
    p_aa_r <= s0_r.a_real * s0_r.a_real;
    p_ab_r <= s0_r.a_imag * s0_r.a_imag;
    p_ba_r <= s0_r.b_real * s0_r.b_real;
    p_bb_r <= s0_r.b_imag * s0_r.b_imag;
    as1_r  <= as_nxt;
    asi1_r <= asi_nxt;
    eq1_r  <= (s0_r.a_real == s0_r.b_real) && (s0_r.a_imag == s0_r.b_imag);
  end

  // stage 2: sums
  logic                 v2_r;
  logic [3:0]           cmd2_r;
  logic signed [SW-1:0] mre2_r, mim2_r, dre2_r, dim2_r;
  logic [PW-1:0]        ma2_r, mb2_r;
  logic signed [DW:0]   as2_r, asi2_r;
  logic                 eq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    cmd2_r <= cmd1_r;
    mre2_r <= SW'(p_rr_r) - SW'(p_ii_r);
    mim2_r <= SW'(p_ri_r) + SW'(p_ir_r);
    dre2_r <= SW'(p_rr_r) + SW'(p_ii_r);
    dim2_r <= SW'(p_ir_r) - SW'(p_ri_r);
    ma2_r  <= PW'(SW'(p_aa_r) + SW'(p_ab_r));
    mb2_r  <= PW'(SW'(p_ba_r) + SW'(p_bb_r));
    as2_r  <= as1_r;
    asi2_r <= asi1_r;
    eq2_r  <= eq1_r;
  end

  // stage 3: saturate, compare, divider setup
  logic [SW-1:0] mm_re, mm_im, dm_re, dm_im, am_re, am_im;
  logic [DW:0]   ms_re, ms_im, as_re, as_im;
  logic [RW-1:0] n_re, n_im, den_top;
  ctl_t          c3_nxt;
  logic          v3_r;
  ctl_t          c3_r;
  logic [RW-1:0] n_re_r, n_im_r;
  logic [PW-1:0] den_r;

  always_comb begin
    mm_re = mre2_r[SW-1] ? SW'(-mre2_r) : SW'(mre2_r);
    mm_im = mim2_r[SW-1] ? SW'(-mim2_r) : SW'(mim2_r);
    ms_re = sat_mag(mm_re >> FW, mre2_r[SW-1]);
    ms_im = sat_mag(mm_im >> FW, mim2_r[SW-1]);
    am_re = as2_r[DW]  ? SW'({1'b0, -as2_r}) : SW'({1'b0, as2_r});
    am_im = asi2_r[DW] ? SW'({1'b0, -asi2_r}) : SW'({1'b0, asi2_r});
    as_re = sat_mag(am_re, as2_r[DW]);
    as_im = sat_mag(am_im, asi2_r[DW]);
    dm_re = dre2_r[SW-1] ? SW'(-dre2_r) : SW'(dre2_r);
    dm_im = dim2_r[SW-1] ? SW'(-dim2_r) : SW'(dim2_r);
    n_re    = RW'(dm_re) << FW;
    n_im    = RW'(dm_im) << FW;
    den_top = RW'(mb2_r) << DW;

    c3_nxt        = '0;
    c3_nxt.cmd    = cmd2_r;
    c3_nxt.dz     = (mb2_r == '0);
    c3_nxt.neg_re = dre2_r[SW-1];
    c3_nxt.neg_im = dim2_r[SW-1];
    c3_nxt.ovf_re = (n_re >= den_top);
    c3_nxt.ovf_im = (n_im >= den_top);
    case (cau_cmd_t'(cmd2_r))
      CMD_ADD, CMD_SUB: begin
        c3_nxt.res_re = as_re[DW-1:0];
        c3_nxt.res_im = as_im[DW-1:0];
        c3_nxt.sat    = as_re[DW] | as_im[DW];
      end
      CMD_MUL: begin
        c3_nxt.res_re = ms_re[DW-1:0];
        c3_nxt.res_im = ms_im[DW-1:0];
        c3_nxt.sat    = ms_re[DW] | ms_im[DW];
      end
      CMD_EQ: c3_nxt.cmp = eq2_r;
      CMD_NE: c3_nxt.cmp = !eq2_r;
      CMD_LT: c3_nxt.cmp = (ma2_r < mb2_r);
      CMD_GT: c3_nxt.cmp = (ma2_r > mb2_r);
      CMD_LE: c3_nxt.cmp = (ma2_r <= mb2_r);
      CMD_GE: c3_nxt.cmp = (ma2_r >= mb2_r);
      default: c3_nxt.cmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    c3_r   <= c3_nxt;
    n_re_r <= n_re;
    n_im_r <= n_im;
    den_r  <= mb2_r;
  end

  // divider stages, control travels alongside
  logic [DW-1:0] q_re, q_im;

  cau_div u_div_re (.clk(clk), .num_i(n_re_r), .den_i(den_r), .quo_o(q_re));
  cau_div u_div_im (.clk(clk), .num_i(n_im_r), .den_i(den_r), .quo_o(q_im));

  logic [DW-1:0] dv_r;
  ctl_t          dl_r [DW];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else        dv_r <= {dv_r[DW-2:0], v3_r};
  end

  always_ff @(posedge clk) begin
    dl_r[0] <= c3_r;
    for (int k = 1; k < DW; k++) dl_r[k] <= dl_r[k-1];
  end

  // output stage
  ctl_t          ct;
  logic [DW:0]   qs_re, qs_im;
  cau_out_t      out_nxt;
  logic          out_valid_r;
  cau_out_t      out_data_r;

  assign ct = dl_r[DW-1];

  always_comb begin
    qs_re = sat_mag(ct.ovf_re ? {SW{1'b1}} : SW'(q_re), ct.neg_re);
    qs_im = sat_mag(ct.ovf_im ? {SW{1'b1}} : SW'(q_im), ct.neg_im);
    out_nxt              = '0;
    out_nxt.compare_true = ct.cmp;
    if (cau_cmd_t'(ct.cmd) == CMD_DIV) begin
      if (ct.dz) begin
        out_nxt.status = ST_DIVZ;
      end else begin
        out_nxt.result_real = qs_re[DW-1:0];
        out_nxt.result_imag = qs_im[DW-1:0];
        out_nxt.status      = (qs_re[DW] | qs_im[DW]) ? ST_SAT : ST_OK;
      end
    end else begin
      out_nxt.result_real = ct.res_re;
      out_nxt.result_imag = ct.res_im;
      out_nxt.status      = ct.sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[DW-1];
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/cau_chk.sv
module cau_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##CAU_LATENCY out_valid)
    else $error("accepted transaction gave no result");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, CAU_LATENCY))
    else $error("result without accepted transaction");

  a_divz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DIVZ) |->
      (out_data.result_real == '0 && out_data.result_imag == '0 && !out_data.compare_true))
    else $error("divide by zero result not cleared");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.compare_true) |->
      (out_data.status == ST_OK && out_data.result_real == '0 &&
       out_data.result_imag == '0))
    else $error("compare result carries value or status");

endmodule

bind complex_arithmetic_unit_core cau_chk u_cau_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

### verif/tb_complex_arithmetic_unit_core.sv
module tb_complex_arithmetic_unit_core;
  import cau_pkg::*;

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_CYCLES = CAU_LATENCY + 10;
  localparam longint Q_MAX = 32767;
  localparam longint Q_MIN = -32768;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  cau_in_t  in_data = '0;
  logic     out_valid;
  cau_out_t out_data;

  cau_in_t  pending_q[$];
  int       idle_pct_q[$];
  cau_out_t expected_q[$];
  int       mismatches = 0;
  int       accepted = 0;
  int       checked = 0;
  int       cycles = 0;
  int       cmd_seen[16];

  complex_arithmetic_unit_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp_q(input longint v, inout logic clamped);
    if (v > Q_MAX) begin
      clamped = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clamped = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic longint drop_frac(input longint v);
    longint m;
    m = (v < 0 ? -v : v) >>> FW;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint frac_quotient(input longint num, input longint den);
    longint m;
    m = ((num < 0 ? -num : num) << FW) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic cau_out_t predict_cau(input cau_in_t t);
    cau_out_t r;
    longint ar, ai, br, bi, ma, mb, rr, ri;
    logic clamped, cmp;
    logic [1:0] st;
    ar = $signed(t.a_real);
    ai = $signed(t.a_imag);
    br = $signed(t.b_real);
    bi = $signed(t.b_imag);
    ma = ar * ar + ai * ai;
    mb = br * br + bi * bi;
    rr = 0;
    ri = 0;
    clamped = 1'b0;
    cmp = 1'b0;
    st = ST_OK;
    case (t.command)
      CMD_ADD: begin
        rr = clamp_q(ar + br, clamped);
        ri = clamp_q(ai + bi, clamped);
      end
      CMD_SUB: begin
        rr = clamp_q(ar - br, clamped);
        ri = clamp_q(ai - bi, clamped);
      end
      CMD_MUL: begin
        rr = clamp_q(drop_frac(ar * br - ai * bi), clamped);
        ri = clamp_q(drop_frac(ar * bi + ai * br), clamped);
      end
      CMD_DIV: begin
        if (mb == 0) begin
          st = ST_DIVZ;
        end else begin
          rr = clamp_q(frac_quotient(ar * br + ai * bi, mb), clamped);
          ri = clamp_q(frac_quotient(ai * br - ar * bi, mb), clamped);
        end
      end
      CMD_EQ: cmp = (ar == br) && (ai == bi);
      CMD_NE: cmp = (ar != br) || (ai != bi);
      CMD_LT: cmp = ma < mb;
      CMD_GT: cmp = ma > mb;
      CMD_LE: cmp = ma <= mb;
      CMD_GE: cmp = ma >= mb;
      default: ;
    endcase
    if (clamped) st = ST_SAT;
    r.result_real  = rr[DW-1:0];
    r.result_imag  = ri[DW-1:0];
    r.compare_true = cmp;
    r.status       = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR @%0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DW-1:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return DW'($signed($urandom_range(0, 1023)) - 512);
      3: return 16'h0000;
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [3:0] cmd, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                            input logic [DW-1:0] br, input logic [DW-1:0] bi, input int idle_pct);
    cau_in_t t;
    t.command = cmd;
    t.a_real  = ar;
    t.a_imag  = ai;
    t.b_real  = br;
    t.b_imag  = bi;
    pending_q.push_back(t);
    idle_pct_q.push_back(idle_pct);
  endtask

  // driver: take the transaction, then present the next one
  always @(posedge clk) begin
    int pct;
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      expected_q.push_back(predict_cau(in_data));
      cmd_seen[in_data.command]++;
      accepted++;
    end
    if (rst_n && (!start || !busy)) begin
      if (pending_q.size() > 0) begin
        pct = idle_pct_q[0];
        if ($urandom_range(0, 99) >= pct) begin
          in_data <= pending_q.pop_front();
          void'(idle_pct_q.pop_front());
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cau_out_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("ERROR @%0d: result with no transaction outstanding", cycles);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (out_data.result_real !== want.result_real)
          report_mismatch("result_real", out_data.result_real, want.result_real);
        if (out_data.result_imag !== want.result_imag)
          report_mismatch("result_imag", out_data.result_imag, want.result_imag);
        if (out_data.compare_true !== want.compare_true)
          report_mismatch("compare_true", out_data.compare_true, want.compare_true);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("complex_arithmetic_unit_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [DW-1:0] ar, ai, br, bi;
    logic [3:0] cmd;
    int pct;
    for (int c = 0; c <= CMD_GE; c++) begin
      queue_item(4'(c), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
      queue_item(4'(c), 16'h8000, 16'h7fff, 16'h0100, 16'hff00, 0);
    end
    queue_item(CMD_DIV, 16'h1234, 16'hedcc, 16'h0000, 16'h0000, 0);
    queue_item(CMD_DIV, 16'hff80, 16'h0180, 16'h0200, 16'hfe00, 0);
    queue_item(CMD_MUL, 16'hff01, 16'h0000, 16'h00ff, 16'h0000, 0);
    queue_item(4'd10, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 0);
    queue_item(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    for (int i = 0; i < 750; i++) begin
      case (i / 188)
        0: pct = 0;
        1: pct = 75;
        2: pct = 29;
        default: pct = (i % 50 < 25) ? 0 : 75;
      endcase
      cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      ar = pick_part();
      ai = pick_part();
      br = pick_part();
      bi = pick_part();
      case ($urandom_range(0, 9))
        0: begin
          br = ar;
          bi = ai;
        end
        1: begin
          br = ai;
          bi = ar;
        end
        2: begin
          br = '0;
          bi = '0;
        end
        default: ;
      endcase
      queue_item(cmd, ar, ai, br, bi, pct);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || start) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d mismatches", accepted, checked,
             mismatches);
    $display("commands add..ge seen: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d, unused: %0d",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4], cmd_seen[5],
             cmd_seen[6], cmd_seen[7], cmd_seen[8], cmd_seen[9],
             cmd_seen[10] + cmd_seen[11] + cmd_seen[12] + cmd_seen[13] + cmd_seen[14]
             + cmd_seen[15]);
    if (mismatches == 0) begin
      $display("complex_arithmetic_unit_core: match");
    end else begin
      $display("complex_arithmetic_unit_core: mismatch");
    end
    $finish;
  end

endmodule
